// ===== hdl/arpc_pkg.sv =====
`timescale 1ns / 1ps
// arpc_pkg: shared types and constants of the ARP cache with entry lifetime.
// Used by every module of the block; depends on nothing.
package arpc_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned MCAST_BIT   = 40;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_MAC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd4;

  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd60000;
  localparam logic [IP_W-1:0]   MASK_RST     = 32'hFFFF_FF00;

  localparam int unsigned S_DATA_W = 112;
  localparam int unsigned M_DATA_W = 88;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_STORED    = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NOT_READY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_STORE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [MAC_W-1:0]  hw;
    logic [IP_W-1:0]   ipv4;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] age;
    logic              expired;
    logic              older;
  } age_res_t;

endpackage

// ===== hdl/arp_cache_ttl_table_core.sv =====
`timescale 1ns / 1ps
// ARP cache with entry lifetime: an IPv4-to-MAC table of ENTRIES entries. One
// item is taken at a time. Lookups and stores walk the entries one per cycle
// through the single read port of the entry RAM and one shared age unit. An
// item is checked, then scanned, then for a store written, and its result is
// registered once the output is free; a lookup ends its scan at the first live
// hit, and an item that is not ready or rejected skips the scan. Valid bits
// live in flops cleared by reset, so no clearing pass is needed and the block
// is usable right after reset.
// Depends on arpc_pkg, arpc_entry_ram and arpc_age_unit.
module arp_cache_ttl_table_core #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: peer_ipv4[31:0], peer_hw_address[79:32], now_ms[111:80]
  input  logic [arpc_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // tuser: op
  input  logic                               s_axis_tuser,
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: status[2:0], found_hw_address[50:3], updates_total[82:51], zero pad
  output logic [arpc_pkg::M_DATA_W-1:0]      m_axis_tdata
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // config registers
  logic              enabled_q;
  logic [TIME_W-1:0] lifetime_q;
  logic [MAC_W-1:0]  dev_mac_q;
  logic [IP_W-1:0]   own_ip_q;
  logic [IP_W-1:0]   mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      lifetime_q <= LIFETIME_RST;
      dev_mac_q  <= '0;
      own_ip_q   <= '0;
      mask_q     <= MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLED:  enabled_q  <= cfg_wdata_i[0];
        CFG_LIFETIME: lifetime_q <= cfg_wdata_i[TIME_W-1:0];
        CFG_DEV_MAC:  dev_mac_q  <= cfg_wdata_i[MAC_W-1:0];
        CFG_OWN_IP:   own_ip_q   <= cfg_wdata_i[IP_W-1:0];
        CFG_MASK:     mask_q     <= cfg_wdata_i[IP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [IP_W-1:0]    ip_q, ip_d;
  logic [MAC_W-1:0]   mac_q, mac_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               has_match_q, has_match_d;
  logic [IDX_W-1:0]   match_q, match_d;
  logic               has_vac_q, has_vac_d;
  logic [IDX_W-1:0]   vac_q, vac_d;
  logic               has_old_q, has_old_d;
  logic [IDX_W-1:0]   old_q, old_d;
  logic [TIME_W-1:0]  old_age_q, old_age_d;
  status_e            status_q, status_d;
  logic [MAC_W-1:0]   found_q, found_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   count_q, count_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [MAC_W-1:0]   out_found_q, out_found_d;
  logic [CNT_W-1:0]   out_count_q, out_count_d;

  // RAM and age unit hookup
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  age_res_t           age_res;
  logic               args_ok;
  logic               cur_valid, cur_live, ip_hit, is_last;
  logic [IDX_W-1:0]   chosen;

  arpc_entry_ram #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  arpc_age_unit u_age (
    .now_i      (now_q),
    .stamp_i    (ram_rdata.stamp),
    .lifetime_i (lifetime_q),
    .best_age_i (old_age_q),
    .res_o      (age_res)
  );

  assign args_ok = ((ip_q & mask_q) == (own_ip_q & mask_q)) && (ip_q != own_ip_q) &&
                   (mac_q != '0) && !mac_q[MCAST_BIT] && (mac_q != dev_mac_q);

  assign cur_valid = valid_q[idx_q];
  assign cur_live  = cur_valid && !age_res.expired;
  assign ip_hit    = (ram_rdata.ipv4 == ip_q);
  assign is_last   = (idx_q == LAST_IDX);
  assign chosen    = has_match_q ? match_q : (has_vac_q ? vac_q : old_q);

  assign ram_waddr       = chosen;
  assign ram_wdata.ipv4  = ip_q;
  assign ram_wdata.hw    = mac_q;
  assign ram_wdata.stamp = now_q;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ip_d        = ip_q;
    mac_d       = mac_q;
    now_d       = now_q;
    idx_d       = idx_q;
    has_match_d = has_match_q;
    match_d     = match_q;
    has_vac_d   = has_vac_q;
    vac_d       = vac_q;
    has_old_d   = has_old_q;
    old_d       = old_q;
    old_age_d   = old_age_q;
    status_d    = status_q;
    found_d     = found_q;
    valid_d     = valid_q;
    count_d     = count_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          ip_d    = s_axis_tdata[31:0];
          mac_d   = s_axis_tdata[79:32];
          now_d   = s_axis_tdata[111:80];
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        found_d     = '0;
        idx_d       = '0;
        has_match_d = 1'b0;
        has_vac_d   = 1'b0;
        has_old_d   = 1'b0;
        old_age_d   = '0;
        match_d     = '0;
        vac_d       = '0;
        old_d       = '0;
        ram_re      = 1'b1;
        if (!enabled_q) begin
          status_d = ST_NOT_READY;
          state_d  = S_DONE;
        end else if (op_q == OP_STORE && !args_ok) begin
          status_d = ST_INVALID;
          state_d  = S_DONE;
        end else begin
          status_d = ST_MISS;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re    = !is_last;
        ram_raddr = is_last ? '0 : IDX_W'(idx_q + IDX_W'(1));
        idx_d     = ram_raddr;
        if (cur_valid && age_res.expired) begin
          valid_d[idx_q] = 1'b0;
        end
        if (op_q == OP_LOOKUP) begin
          if (cur_live && ip_hit) begin
            status_d = ST_HIT;
            found_d  = ram_rdata.hw;
            state_d  = S_DONE;
          end else if (is_last) begin
            state_d = S_DONE;
          end
        end else begin
          // later match wins; match counts even when expired
          if (cur_valid && ip_hit) begin
            has_match_d = 1'b1;
            match_d     = idx_q;
          end
          if (!cur_live) begin
            if (!has_vac_q) begin
              has_vac_d = 1'b1;
              vac_d     = idx_q;
            end
          end else if (!has_old_q || age_res.older) begin
            has_old_d = 1'b1;
            old_d     = idx_q;
            old_age_d = age_res.age;
          end
          if (is_last) begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        ram_we          = 1'b1;
        valid_d[chosen] = 1'b1;
        count_d         = count_q + CNT_W'(1);
        status_d        = ST_STORED;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = found_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      has_match_q <= 1'b0;
      has_vac_q   <= 1'b0;
      has_old_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      has_match_q <= has_match_d;
      has_vac_q   <= has_vac_d;
      has_old_q   <= has_old_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ip_q         <= ip_d;
    mac_q        <= mac_d;
    now_q        <= now_d;
    match_q      <= match_d;
    vac_q        <= vac_d;
    old_q        <= old_d;
    old_age_q    <= old_age_d;
    status_q     <= status_d;
    found_q      <= found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_count_q, out_found_q, out_status_q};

`ifndef SYNTHESIS
  a_write_is_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (op_q == OP_STORE))
    else $error("entry write for a lookup");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> (valid_q != '0))
    else $error("no valid entry after store");

  a_count_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_WRITE) |=> (count_q == $past(count_q)))
    else $error("update count moved without a store");

  a_scan_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= LAST_IDX))
    else $error("scan index out of range");
`endif

endmodule

// ===== hdl/arpc_entry_ram.sv =====
`timescale 1ns / 1ps
// arpc_entry_ram: entry storage, one write port and one registered read port.
// Depends on arpc_pkg for the entry type.
module arpc_entry_ram #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  arpc_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output arpc_pkg::entry_t     rdata_o
);
  import arpc_pkg::*;

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/arpc_age_unit.sv =====
`timescale 1ns / 1ps
// arpc_age_unit: shared age unit; wrapping age, expiry and oldest compare.
// Depends on arpc_pkg for widths and the result struct.
module arpc_age_unit (
  input  logic [arpc_pkg::TIME_W-1:0] now_i,
  input  logic [arpc_pkg::TIME_W-1:0] stamp_i,
  input  logic [arpc_pkg::TIME_W-1:0] lifetime_i,
  input  logic [arpc_pkg::TIME_W-1:0] best_age_i,
  output arpc_pkg::age_res_t          res_o
);
  import arpc_pkg::*;

  logic [TIME_W-1:0] age;

  assign age           = now_i - stamp_i;
  assign res_o.age     = age;
  assign res_o.expired = (age >= lifetime_i);
  assign res_o.older   = (age > best_age_i);

endmodule
